/* rtl/core/rrp_pkg.sv */
// rrp_pkg: types, codes and constants of the multi-bulk request parser
// used by rrp_accum, rrp_step and resp_request_parser_unit; no dependencies

package rrp_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned LengthW = 30;
  localparam int unsigned NumW    = 32;
  localparam int unsigned ByteW   = 8;

  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam logic [CountW-1:0]  MaxCountRst  = 16'd1024;
  localparam logic [LengthW-1:0] MaxLengthRst = 30'd536870912;

  typedef enum logic [2:0] {
    PH_HDR_START = 3'd0,
    PH_HDR_LINE  = 3'd1,
    PH_ARG_START = 3'd2,
    PH_ARG_LINE  = 3'd3,
    PH_DATA      = 3'd4,
    PH_DATA_CR   = 3'd5,
    PH_DATA_LF   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_DATA    = 3'd1,
    K_ARG_END = 3'd2,
    K_REQ_END = 3'd3,
    K_ERROR   = 3'd4
  } kind_e;

  typedef enum logic {
    CFG_MAX_ARG_COUNT  = 1'b0,
    CFG_MAX_ARG_LENGTH = 1'b1
  } cfg_e;

  typedef struct packed {
    phase_e             phase;
    logic [NumW-1:0]    accum;
    logic               closed;
    logic [ByteW-1:0]   prev;
    logic [CountW-1:0]  args_left;
    logic [LengthW-1:0] data_left;
    logic [CountW-1:0]  cur_arg;
    logic [NumW-1:0]    total;
  } state_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [CountW-1:0] idx;
    logic [NumW-1:0]  total;
  } result_t;

  localparam state_t StateRst = '{
    phase:     PH_HDR_START,
    accum:     '0,
    closed:    1'b0,
    prev:      '0,
    args_left: '0,
    data_left: '0,
    cur_arg:   '0,
    total:     '0
  };

endpackage

/* rtl/core/rrp_accum.sv */
// rrp_accum: saturating decimal digit accumulator (acc * 10 + digit)
// depends on rrp_pkg for widths and character constants

module rrp_accum (
  input  logic [rrp_pkg::NumW-1:0]  acc_i,
  input  logic [rrp_pkg::ByteW-1:0] byte_i,
  output logic                      is_digit_o,
  output logic [rrp_pkg::NumW-1:0]  acc_o
);

  logic [3:0]              digit;
  logic [rrp_pkg::NumW+3:0] prod;
  logic [rrp_pkg::NumW+3:0] sum;

  assign is_digit_o = (byte_i >= rrp_pkg::ChZero) && (byte_i <= rrp_pkg::ChNine);
  assign digit      = byte_i[3:0];

  // times ten as x*8 + x*2, four spare bits catch overflow
  assign prod = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0};
  assign sum  = prod + {{rrp_pkg::NumW{1'b0}}, digit};

  assign acc_o = (sum[rrp_pkg::NumW+3:rrp_pkg::NumW] != 4'd0) ? '1 : sum[rrp_pkg::NumW-1:0];

endmodule

/* rtl/core/rrp_step.sv */
// rrp_step: next parser state and result for one byte
// depends on rrp_pkg and rrp_accum

module rrp_step (
  input  rrp_pkg::state_t              st_i,
  input  logic [rrp_pkg::ByteW-1:0]    byte_i,
  input  logic [rrp_pkg::CountW-1:0]   max_count_i,
  input  logic [rrp_pkg::LengthW-1:0]  max_length_i,
  output rrp_pkg::state_t              st_o,
  output rrp_pkg::result_t             res_o
);

  logic                        is_digit;
  logic [rrp_pkg::NumW-1:0]    acc_next;
  logic [rrp_pkg::NumW-1:0]    total_inc;
  logic [rrp_pkg::LengthW-1:0] data_left_dec;
  rrp_pkg::state_t             nxt;
  rrp_pkg::result_t            res;

  rrp_accum u_accum (
    .acc_i      (st_i.accum),
    .byte_i     (byte_i),
    .is_digit_o (is_digit),
    .acc_o      (acc_next)
  );

  assign total_inc     = (st_i.total == '1) ? st_i.total : st_i.total + 1'b1;
  assign data_left_dec = st_i.data_left - 1'b1;

  always_comb begin
    nxt       = st_i;
    nxt.total = total_inc;
    res       = '{kind: rrp_pkg::K_NONE, data: '0, idx: '0, total: '0};

    case (st_i.phase)
      rrp_pkg::PH_HDR_LINE, rrp_pkg::PH_ARG_LINE: begin
        if (byte_i != rrp_pkg::ChLf) begin
          if (!st_i.closed && is_digit) begin
            nxt.accum = acc_next;
          end else begin
            nxt.closed = 1'b1;
          end
        end else if (st_i.prev != rrp_pkg::ChCr) begin
          res.kind = rrp_pkg::K_ERROR;
        end else if (st_i.phase == rrp_pkg::PH_HDR_LINE) begin
          if (st_i.accum > {{(rrp_pkg::NumW-rrp_pkg::CountW){1'b0}}, max_count_i}) begin
            res.kind = rrp_pkg::K_ERROR;
          end else if (st_i.accum == '0) begin
            res.kind  = rrp_pkg::K_REQ_END;
            res.total = total_inc;
          end else begin
            // count is within a 16 bit limit here
            nxt.args_left = st_i.accum[rrp_pkg::CountW-1:0];
            nxt.cur_arg   = '0;
            nxt.phase     = rrp_pkg::PH_ARG_START;
          end
        end else begin
          if (st_i.accum > {{(rrp_pkg::NumW-rrp_pkg::LengthW){1'b0}}, max_length_i}) begin
            res.kind = rrp_pkg::K_ERROR;
          end else begin
            nxt.data_left = st_i.accum[rrp_pkg::LengthW-1:0];
            nxt.phase     = (st_i.accum == '0) ? rrp_pkg::PH_DATA_CR : rrp_pkg::PH_DATA;
          end
        end
      end
      rrp_pkg::PH_ARG_START: begin
        if (byte_i == rrp_pkg::ChDollar) begin
          nxt.accum  = '0;
          nxt.closed = 1'b0;
          nxt.phase  = rrp_pkg::PH_ARG_LINE;
        end else begin
          res.kind = rrp_pkg::K_ERROR;
        end
      end
      rrp_pkg::PH_DATA: begin
        res.kind      = rrp_pkg::K_DATA;
        res.data      = byte_i;
        res.idx       = st_i.cur_arg;
        nxt.data_left = data_left_dec;
        if (data_left_dec == '0) begin
          nxt.phase = rrp_pkg::PH_DATA_CR;
        end
      end
      rrp_pkg::PH_DATA_CR: begin
        if (byte_i == rrp_pkg::ChCr) begin
          nxt.phase = rrp_pkg::PH_DATA_LF;
        end else begin
          res.kind = rrp_pkg::K_ERROR;
        end
      end
      rrp_pkg::PH_DATA_LF: begin
        if (byte_i != rrp_pkg::ChLf) begin
          res.kind = rrp_pkg::K_ERROR;
        end else if (st_i.args_left <= rrp_pkg::CountW'(1)) begin
          res.kind  = rrp_pkg::K_REQ_END;
          res.total = total_inc;
        end else begin
          res.kind      = rrp_pkg::K_ARG_END;
          res.idx       = st_i.cur_arg;
          nxt.args_left = st_i.args_left - 1'b1;
          nxt.cur_arg   = st_i.cur_arg + 1'b1;
          nxt.phase     = rrp_pkg::PH_ARG_START;
        end
      end
      default: begin
        // header start, and the unused phase code
        if (byte_i == rrp_pkg::ChStar) begin
          nxt.accum  = '0;
          nxt.closed = 1'b0;
          nxt.phase  = rrp_pkg::PH_HDR_LINE;
        end else begin
          res.kind = rrp_pkg::K_ERROR;
        end
      end
    endcase

    nxt.prev = byte_i;
    if (res.kind == rrp_pkg::K_ERROR || res.kind == rrp_pkg::K_REQ_END) begin
      nxt = rrp_pkg::StateRst;
    end

    st_o  = nxt;
    res_o = res;
  end

endmodule

/* rtl/core/resp_request_parser_unit.sv */
// resp_request_parser_unit: top level of the multi-bulk request parser
// depends on rrp_pkg and rrp_step (which uses rrp_accum)
//
//   channel   handshake                 payload
//   in        in_valid_i / in_ready_o   in_byte_i
//   out       out_valid_o / out_ready_i result_kind_o, data_byte_o, arg_index_o,
//                                       request_bytes_o
//   cfg       cfg_we_i                  cfg_index_i, cfg_data_i
//
// one byte per cycle sustained while the result register is not stalled; a byte's result
// passes the input register, then the result register, set by the single state update path
// a byte waits in the input register while the result register is stalled;
// the input register still takes a beat whenever it is empty
// reset clears the parser state and loads the limits with 1024 and 2^29

module resp_request_parser_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rrp_pkg::ByteW-1:0]        in_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       result_kind_o,
  output logic [rrp_pkg::ByteW-1:0]        data_byte_o,
  output logic [rrp_pkg::CountW-1:0]       arg_index_o,
  output logic [rrp_pkg::NumW-1:0]         request_bytes_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_index_i,
  input  logic [rrp_pkg::LengthW-1:0]      cfg_data_i
);

  logic                        in_vld_q;
  logic [rrp_pkg::ByteW-1:0]   in_byte_q;
  logic                        out_vld_q;
  rrp_pkg::result_t            res_q;
  rrp_pkg::result_t            res_d;
  rrp_pkg::state_t             st_q;
  rrp_pkg::state_t             st_d;
  logic [rrp_pkg::CountW-1:0]  max_count_q;
  logic [rrp_pkg::LengthW-1:0] max_length_q;
  logic                        advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  rrp_step u_step (
    .st_i         (st_q),
    .byte_i       (in_byte_q),
    .max_count_i  (max_count_q),
    .max_length_i (max_length_q),
    .st_o         (st_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= rrp_pkg::StateRst;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q  <= rrp_pkg::MaxCountRst;
      max_length_q <= rrp_pkg::MaxLengthRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rrp_pkg::CFG_MAX_ARG_COUNT) begin
        max_count_q <= cfg_data_i[rrp_pkg::CountW-1:0];
      end else begin
        max_length_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign result_kind_o   = res_q.kind;
  assign data_byte_o     = res_q.data;
  assign arg_index_o     = res_q.idx;
  assign request_bytes_o = res_q.total;

  // an error or request end always leaves the parser back at a fresh header
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.kind == rrp_pkg::K_ERROR || res_d.kind == rrp_pkg::K_REQ_END)
    |=> st_q.phase == rrp_pkg::PH_HDR_START && st_q.total == '0 && st_q.prev == '0)
    else $error("parser did not restart after error or request end");

  // a held byte must not be lost or altered while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_byte_q))
    else $error("input register changed while stalled");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != rrp_pkg::K_DATA |-> data_byte_o == '0)
    else $error("data byte set on a non-data beat");

  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != rrp_pkg::K_REQ_END |-> request_bytes_o == '0)
    else $error("byte total set on a beat that is not request end");

endmodule
